// File: rtl/core/ttb_pkg.sv
// Shared types, widths and corner codes of the tangent-space block.
package ttb_pkg;

  localparam int PosW   = 32;
  localparam int UvW    = 24;
  localparam int OutW   = 16;
  localparam int DposW  = 33;
  localparam int DuvW   = 25;
  localparam int ProdW  = 58;
  localparam int MagW   = 57;
  localparam int QDepth = 2;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  // One complete triangle: deltas, handed from the front to the back.
  typedef struct packed {
    logic signed [DposW-1:0] d0x;
    logic signed [DposW-1:0] d0y;
    logic signed [DposW-1:0] d0z;
    logic signed [DposW-1:0] d1x;
    logic signed [DposW-1:0] d1y;
    logic signed [DposW-1:0] d1z;
    logic signed [DuvW-1:0]  tuu;
    logic signed [DuvW-1:0]  tuv;
    logic signed [DuvW-1:0]  tvu;
    logic signed [DuvW-1:0]  tvv;
  } tri_t;

  typedef struct packed {
    logic signed [OutW-1:0] tx;
    logic signed [OutW-1:0] ty;
    logic signed [OutW-1:0] tz;
    logic signed [OutW-1:0] bx;
    logic signed [OutW-1:0] by;
    logic signed [OutW-1:0] bz;
    logic                   zero;
  } res_t;

endpackage

// File: rtl/core/ttb_front.sv
// Front end: holds corners 0 and 1 and forms the deltas on corner 2.
module ttb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_corner,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_x,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_y,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_z,
  input  logic signed [ttb_pkg::UvW-1:0]  in_tex_u,
  input  logic signed [ttb_pkg::UvW-1:0]  in_tex_v,
  output logic                          q_valid,
  input  logic                          q_ready,
  output ttb_pkg::tri_t                 q_data
);

  logic signed [ttb_pkg::PosW-1:0] p0x_r, p0y_r, p0z_r, p1x_r, p1y_r, p1z_r;
  logic signed [ttb_pkg::UvW-1:0]  u0_r, v0_r, u1_r, v1_r;
  logic                            take;

  // Only a completing corner needs room in the queue.
  assign in_ready = (in_corner != ttb_pkg::CORNER_2) || q_ready;
  assign take     = in_valid && in_ready;
  assign q_valid  = in_valid && (in_corner == ttb_pkg::CORNER_2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0x_r <= '0; p0y_r <= '0; p0z_r <= '0;
      p1x_r <= '0; p1y_r <= '0; p1z_r <= '0;
      u0_r  <= '0; v0_r  <= '0; u1_r  <= '0; v1_r <= '0;
    end else if (take && in_corner == ttb_pkg::CORNER_0) begin
      p0x_r <= in_pos_x; p0y_r <= in_pos_y; p0z_r <= in_pos_z;
      u0_r  <= in_tex_u; v0_r  <= in_tex_v;
    end else if (take && in_corner == ttb_pkg::CORNER_1) begin
      p1x_r <= in_pos_x; p1y_r <= in_pos_y; p1z_r <= in_pos_z;
      u1_r  <= in_tex_u; v1_r  <= in_tex_v;
    end
  end

  always_comb begin
    q_data.d0x = ttb_pkg::DposW'(p1x_r) - ttb_pkg::DposW'(p0x_r);
    q_data.d0y = ttb_pkg::DposW'(p1y_r) - ttb_pkg::DposW'(p0y_r);
    q_data.d0z = ttb_pkg::DposW'(p1z_r) - ttb_pkg::DposW'(p0z_r);
    q_data.d1x = ttb_pkg::DposW'(in_pos_x) - ttb_pkg::DposW'(p0x_r);
    q_data.d1y = ttb_pkg::DposW'(in_pos_y) - ttb_pkg::DposW'(p0y_r);
    q_data.d1z = ttb_pkg::DposW'(in_pos_z) - ttb_pkg::DposW'(p0z_r);
    q_data.tuu = ttb_pkg::DuvW'(u1_r) - ttb_pkg::DuvW'(u0_r);
    q_data.tuv = ttb_pkg::DuvW'(v1_r) - ttb_pkg::DuvW'(v0_r);
    q_data.tvu = ttb_pkg::DuvW'(in_tex_u) - ttb_pkg::DuvW'(u0_r);
    q_data.tvv = ttb_pkg::DuvW'(in_tex_v) - ttb_pkg::DuvW'(v0_r);
  end

endmodule

// File: rtl/core/ttb_fifo.sv
// Two-entry queue of triangles between the front and the back.
module ttb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ttb_pkg::tri_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ttb_pkg::tri_t rd_data
);

  ttb_pkg::tri_t mem_r [ttb_pkg::QDepth];
  logic          wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/ttb_back.sv
// Back end: products, cross term, scaling, square root and division by a
// shared sequencer, one step of the long operations per cycle.
module ttb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  ttb_pkg::tri_t q_data,
  output logic          res_valid,
  input  logic          res_ready,
  output ttb_pkg::res_t res_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUB  = 4'd2;
  localparam logic [3:0] S_SHF  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]  st_r, st_nxt;
  ttb_pkg::tri_t t_r;
  // Products of one vector: pa_r holds the first term, pb_r the second.
  logic signed [ttb_pkg::ProdW-1:0] pa_r [3];
  logic signed [ttb_pkg::ProdW-1:0] pb_r [3];
  logic signed [ttb_pkg::ProdW-1:0] c_r [6];
  logic signed [50:0]               cr_a_r, cr_b_r;
  logic        cneg_r, czero_r;
  logic [2:0]  idx_r;            // product step
  logic        vsel_r;           // 0 tangent, 1 binormal
  logic [ttb_pkg::MagW-1:0] mag_r [3];
  logic [63:0] sum_r;
  logic [1:0]  sqi_r;
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  sqk_r;
  logic [1:0]  ci_r;
  logic [47:0] num_r;
  logic [48:0] drem_r;
  logic [15:0] quo_r;
  logic [5:0]  dk_r;
  logic [15:0] o_r [6];
  logic        busy_out_r;

  logic signed [ttb_pkg::DposW-1:0] mdp;
  logic signed [ttb_pkg::DuvW-1:0]  mdu;
  logic signed [ttb_pkg::ProdW-1:0] mprod;
  logic [ttb_pkg::MagW-1:0]         mx;
  logic [31:0]                      sm;
  logic [63:0]                      sq;
  logic signed [ttb_pkg::ProdW-1:0] cv;
  logic [15:0]                      qs;

  assign q_ready   = (st_r == S_IDLE);
  assign res_valid = busy_out_r;
  assign res_data.tx = o_r[0];
  assign res_data.ty = o_r[1];
  assign res_data.tz = o_r[2];
  assign res_data.bx = o_r[3];
  assign res_data.by = o_r[4];
  assign res_data.bz = o_r[5];
  assign res_data.zero = czero_r;

  // Product step idx: tangent uses tvv*d0, tvu*d1; binormal tuu*d1, tuv*d0.
  always_comb begin
    case (idx_r)
      3'd0: begin mdp = t_r.d0x; mdu = t_r.tvv; end
      3'd1: begin mdp = t_r.d0y; mdu = t_r.tvv; end
      3'd2: begin mdp = t_r.d0z; mdu = t_r.tvv; end
      3'd3: begin mdp = t_r.d1x; mdu = t_r.tvu; end
      3'd4: begin mdp = t_r.d1y; mdu = t_r.tvu; end
      3'd5: begin mdp = t_r.d1z; mdu = t_r.tvu; end
      default: begin mdp = '0; mdu = '0; end
    endcase
    if (vsel_r) begin
      case (idx_r)
        3'd0: begin mdp = t_r.d1x; mdu = t_r.tuu; end
        3'd1: begin mdp = t_r.d1y; mdu = t_r.tuu; end
        3'd2: begin mdp = t_r.d1z; mdu = t_r.tuu; end
        3'd3: begin mdp = t_r.d0x; mdu = t_r.tuv; end
        3'd4: begin mdp = t_r.d0y; mdu = t_r.tuv; end
        3'd5: begin mdp = t_r.d0z; mdu = t_r.tuv; end
        default: begin mdp = '0; mdu = '0; end
      endcase
    end
    mprod = ttb_pkg::ProdW'(mdp) * ttb_pkg::ProdW'(mdu);
  end

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    sm    = mag_r[sqi_r][31:0];
    sq    = {32'd0, sm} * {32'd0, sm};
    cv    = c_r[{1'b0, ci_r} + (vsel_r ? 3'd3 : 3'd0)];
    qs    = ((cv < 0) != cneg_r) ? (16'd0 - quo_r) : quo_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_MUL;
      S_MUL:  if (idx_r == 3'd5) st_nxt = S_SUB;
      S_SUB:  st_nxt = S_SHF;
      S_SHF:  if (mx < 57'h8000_0000) st_nxt = S_SQ;
      S_SQ:   if (sqi_r == 2'd2) st_nxt = S_SQRT;
      S_SQRT: if (sqk_r == 6'd31) st_nxt = S_DIV;
      S_DIV:  if (dk_r == 6'd48) st_nxt = S_NEXT;
      S_NEXT: begin
        if (ci_r != 2'd2) st_nxt = S_DIV;
        else if (!vsel_r) st_nxt = S_MUL;
        else st_nxt = S_OUT;
      end
      S_OUT:  if (busy_out_r && res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      busy_out_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_valid && res_ready) busy_out_r <= 1'b0;
      else if (st_r == S_OUT && !busy_out_r) busy_out_r <= 1'b1;
    end
  end

  // The result registers are only rewritten once the previous result has left,
  // since a new triangle enters only after S_OUT completes.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        t_r    <= q_data;
        idx_r  <= 3'd0;
        vsel_r <= 1'b0;
        cr_a_r <= 51'(q_data.tuu) * 51'(q_data.tvv);
        cr_b_r <= 51'(q_data.tuv) * 51'(q_data.tvu);
      end
      S_MUL: begin
        if (idx_r < 3'd3) pa_r[idx_r[1:0]] <= mprod;
        else pb_r[2'(idx_r - 3'd3)] <= mprod;
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd0 && !vsel_r) begin
          cneg_r  <= (cr_a_r - cr_b_r) < 0;
          czero_r <= (cr_a_r == cr_b_r);
        end
      end
      S_SUB: begin
        for (int i = 0; i < 3; i++) begin
          c_r[i + (vsel_r ? 3 : 0)] <= pa_r[i] - pb_r[i];
          mag_r[i] <= ttb_pkg::MagW'(((pa_r[i] - pb_r[i]) < 0) ?
                      (pb_r[i] - pa_r[i]) : (pa_r[i] - pb_r[i]));
        end
        sum_r <= '0;
        sqi_r <= '0;
      end
      S_SHF: begin
        if (!(mx < 57'h8000_0000)) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end
      end
      S_SQ: begin
        sum_r <= sum_r + sq;
        sqi_r <= sqi_r + 2'd1;
        rem_r <= '0;
        root_r <= '0;
        sqk_r <= '0;
      end
      S_SQRT: begin
        // Restoring square root, two radicand bits per step.
        sum_r <= {sum_r[61:0], 2'b00};
        if ({rem_r[61:0], sum_r[63:62]} >= {30'd0, root_r, 2'b01}) begin
          rem_r  <= {rem_r[61:0], sum_r[63:62]} - {30'd0, root_r, 2'b01};
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[61:0], sum_r[63:62]};
          root_r <= {root_r[30:0], 1'b0};
        end
        sqk_r <= sqk_r + 6'd1;
        if (sqk_r == 6'd31) begin
          ci_r   <= '0;
          num_r  <= {1'b0, mag_r[0][31:0], 15'd0};
          drem_r <= '0;
          quo_r  <= '0;
          dk_r   <= '0;
        end
      end
      S_DIV: begin
        // floor(r*16384/len + 1/2) == floor((r*32768 + len) / (2*len)),
        // done as (2*r*16384 + len) / (2*len) by bit-serial restoring divide.
        if (dk_r == 6'd0) begin
          num_r <= {1'b0, mag_r[ci_r][31:0], 15'd0} + {16'd0, root_r} ;
          dk_r  <= 6'd1;
        end else begin
          num_r <= {num_r[46:0], 1'b0};
          if ({drem_r[47:0], num_r[47]} >= {16'd0, root_r, 1'b0}) begin
            drem_r <= {drem_r[47:0], num_r[47]} - {16'd0, root_r, 1'b0};
            quo_r  <= {quo_r[14:0], 1'b1};
          end else begin
            drem_r <= {drem_r[47:0], num_r[47]};
            quo_r  <= {quo_r[14:0], 1'b0};
          end
          dk_r <= dk_r + 6'd1;
        end
      end
      S_NEXT: begin
        o_r[{1'b0, ci_r} + (vsel_r ? 3'd3 : 3'd0)] <= (root_r == 32'd0) ? 16'd0 : qs;
        ci_r   <= ci_r + 2'd1;
        drem_r <= '0;
        quo_r  <= '0;
        dk_r   <= '0;
        if (ci_r == 2'd2 && !vsel_r) begin
          vsel_r <= 1'b1;
          idx_r  <= 3'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/triangle_tangent_binormal.sv
// Top level of the per-triangle tangent and binormal block.
// Channels: the input channel takes one triangle corner per transfer
// (in_corner, position Q16.16, texture coordinate Q7.16). Corners 0 and 1
// are held; corner 2 completes the triangle and yields one result transfer on
// the output channel (unit tangent and binormal in Q1.14 and a flag for a
// zero UV cross term). Corner 3 is taken and ignored.
// Corners 0 and 1 are taken every cycle. A corner 2 enters a two-entry
// queue, and the back end works through it: for each of the two vectors
// six product steps, a subtract, a shift search, three squares, 32
// square-root steps, and per component a load, 48 divide steps and a store.
// That iterative back end sets the throughput: it takes the next triangle only
// once the last result is transferred, with corner 0 and 1 transfers overlapping.
// Reset clears the held corners to zero and empties the queue. When the
// receiver stalls, the result is held in the output registers and the back
// end waits for its transfer; the queue keeps accepting until it is full,
// then corner 2 waits.
module triangle_tangent_binormal (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_corner,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_x,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_y,
  input  logic signed [ttb_pkg::PosW-1:0] in_pos_z,
  input  logic signed [ttb_pkg::UvW-1:0]  in_tex_u,
  input  logic signed [ttb_pkg::UvW-1:0]  in_tex_v,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ttb_pkg::OutW-1:0] out_tangent_x,
  output logic signed [ttb_pkg::OutW-1:0] out_tangent_y,
  output logic signed [ttb_pkg::OutW-1:0] out_tangent_z,
  output logic signed [ttb_pkg::OutW-1:0] out_binormal_x,
  output logic signed [ttb_pkg::OutW-1:0] out_binormal_y,
  output logic signed [ttb_pkg::OutW-1:0] out_binormal_z,
  output logic                            out_uv_area_zero
);

  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  ttb_pkg::tri_t fq_data, bq_data;
  ttb_pkg::res_t res;

  ttb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_corner,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_tex_u, .in_tex_v,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  ttb_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  ttb_back u_back (
    .clk, .rst_n,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .res_valid(out_valid), .res_ready(out_ready), .res_data(res)
  );

  assign out_tangent_x    = res.tx;
  assign out_tangent_y    = res.ty;
  assign out_tangent_z    = res.tz;
  assign out_binormal_x   = res.bx;
  assign out_binormal_y   = res.by;
  assign out_binormal_z   = res.bz;
  assign out_uv_area_zero = res.zero;

endmodule

// File: rtl/core/ttb_checker.sv
// Port checker for the tangent-space block, bound to the top level.
module ttb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_corner,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_tangent_x,
  input logic [15:0] out_binormal_x
);

  // Corners that only update the held values are never stalled.
  a_hold_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && (in_corner == ttb_pkg::CORNER_0 || in_corner == ttb_pkg::CORNER_1)
    |-> in_ready) else $error("held corner stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tangent_x)
    && $stable(out_binormal_x)) else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result right after reset");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");

endmodule

bind triangle_tangent_binormal ttb_checker u_ttb_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_corner, .out_valid, .out_ready,
  .out_tangent_x, .out_binormal_x
);
